// ===== src/fsta_pkg.sv =====
// shared constants, types and codes for the filtered sample tile accumulator
// no dependencies; every other file but fsta_ram imports this package
package fsta_pkg;

  localparam int TABLE_EXTENT    = 16;
  localparam int TILE_MAX_WIDTH  = 64;
  localparam int TILE_MAX_HEIGHT = 64;
  localparam int TABLE_DEPTH     = 256;
  localparam int TABLE_AW        = $clog2(TABLE_DEPTH);
  localparam int ACC_DEPTH       = TILE_MAX_WIDTH * TILE_MAX_HEIGHT;
  localparam int ACC_AW          = $clog2(ACC_DEPTH);
  localparam int SLOT_W          = $clog2(TABLE_EXTENT);
  localparam int CRD_W           = 9;
  localparam int DIST_W          = 18;
  localparam int RADIUS_CAP      = 896;
  localparam int LUM_R           = 13938;
  localparam int LUM_G           = 46868;
  localparam int LUM_B           = 4730;
  localparam int QUEUE_DEPTH     = 2;
  localparam int ACC_W           = 48;
  localparam int WGT_W           = 32;
  localparam int ACC_ROW_W       = 3 * ACC_W + WGT_W;

  typedef enum logic [2:0] {
    CFG_TILE_WIDTH    = 3'd0,
    CFG_TILE_HEIGHT   = 3'd1,
    CFG_RADIUS_X      = 3'd2,
    CFG_RADIUS_Y      = 3'd3,
    CFG_TABLE_SCALE_X = 3'd4,
    CFG_TABLE_SCALE_Y = 3'd5,
    CFG_MAX_LUMINANCE = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_LUM,
    F_CMP,
    F_MUL,
    F_DIV,
    F_CSW,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_ROW,
    B_IDX,
    B_MUL,
    B_ACC
  } back_state_e;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        red;
    logic [31:0]        green;
    logic [31:0]        blue;
    logic [15:0]        sample_weight;
    logic [7:0]         table_index;
    logic signed [15:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]               pixel_x;
    logic [5:0]               pixel_y;
    logic signed [ACC_W-1:0]  sum_red;
    logic signed [ACC_W-1:0]  sum_green;
    logic signed [ACC_W-1:0]  sum_blue;
    logic signed [WGT_W-1:0]  weight_total;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  tile_width;
    logic [6:0]  tile_height;
    logic [9:0]  radius_x;
    logic [9:0]  radius_y;
    logic [19:0] table_scale_x;
    logic [19:0] table_scale_y;
    logic [31:0] max_luminance;
  } cfg_t;

  typedef struct packed {
    logic             nonempty;
    logic [CRD_W-1:0] lo;
    logic [CRD_W-1:0] hi;
  } span_t;

  typedef struct packed {
    logic               is_table;
    logic [7:0]         tab_index;
    logic signed [15:0] tab_value;
    logic [ACC_W-1:0]   csw_red;
    logic [ACC_W-1:0]   csw_green;
    logic [ACC_W-1:0]   csw_blue;
    logic signed [16:0] ctr_x;
    logic signed [16:0] ctr_y;
    logic [CRD_W-1:0]   x_lo;
    logic [CRD_W-1:0]   x_hi;
    logic [CRD_W-1:0]   y_lo;
    logic [CRD_W-1:0]   y_hi;
  } job_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// ===== src/fsta_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module fsta_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fsta_queue.sv =====
// short job queue between the front and the back
// depends on fsta_pkg
module fsta_queue import fsta_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  job_t              q_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = q_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH-1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH-1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_q[wr_q] <= job_i;
    end
  end

endmodule

// ===== src/fsta_front.sv =====
// front: accepts transactions, caps luminance, finds the footprint and queues a job
// depends on fsta_pkg
module fsta_front import fsta_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  in_item_t     in_data_i,
  input  cfg_t         cfg_i,
  input  back_status_t bstat_i,
  output logic         push_o,
  output job_t         job_o,
  input  logic         full_i
);

  front_state_e      state_q, state_d;
  in_item_t          item_q;
  logic [47:0]       lprod_q [3];
  logic [31:0]       lum_q;
  logic [31:0]       col_q [3];
  logic [ACC_W-1:0]  csw_q [3];
  logic [1:0]        ch_q;
  logic [31:0]       rem_q, shf_q;
  logic [4:0]        cnt_q;
  span_t             spx_q, spy_q;

  logic              accept;
  logic [47:0]       lum_sum;
  logic [31:0]       lum;
  span_t             spx, spy;
  logic [63:0]       num;
  logic [32:0]       trial;
  logic              ge;
  logic [31:0]       rem_div, shf_div;

  function automatic span_t calc_span(logic signed [15:0] pos, logic [9:0] rad,
                                      logic [6:0] ext_raw, logic [CRD_W-1:0] ext_cap);
    logic signed [DIST_W-1:0] d, r, a, b, e;
    logic [9:0]               rc;
    span_t                    s;
    rc = (rad > 10'(RADIUS_CAP)) ? 10'(RADIUS_CAP) : rad;
    d  = DIST_W'(pos) - 18'sd128;
    r  = DIST_W'(rc);
    a  = -((r - d) >>> 8);
    b  = ((d + r) >>> 8) + 18'sd1;
    if (CRD_W'(ext_raw) > ext_cap) begin
      e = DIST_W'(ext_cap);
    end else begin
      e = DIST_W'(ext_raw);
    end
    if (a < 18'sd0) begin
      a = '0;
    end
    if (b > e) begin
      b = e;
    end
    s.nonempty = (b > a);
    s.lo       = CRD_W'(a);
    s.hi       = CRD_W'(b);
    return s;
  endfunction

  assign accept  = in_valid_i && !in_stall_o;
  assign lum_sum = lprod_q[0] + lprod_q[1] + lprod_q[2];
  assign lum     = lum_sum[47:16];
  assign spx     = calc_span(item_q.pos_x, cfg_i.radius_x, cfg_i.tile_width,
                             CRD_W'(TILE_MAX_WIDTH));
  assign spy     = calc_span(item_q.pos_y, cfg_i.radius_y, cfg_i.tile_height,
                             CRD_W'(TILE_MAX_HEIGHT));
  assign num     = 64'(col_q[ch_q]) * 64'(cfg_i.max_luminance);

  // one quotient bit a cycle, high half of the dividend is already below the divisor
  assign trial   = {rem_q, shf_q[31]};
  assign ge      = (trial >= {1'b0, lum_q});
  assign rem_div = ge ? 32'(trial - {1'b0, lum_q}) : trial[31:0];
  assign shf_div = {shf_q[30:0], ge};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = in_data_i.kind ? F_PUSH : F_LUM;
        end
      end
      F_LUM: state_d = F_CMP;
      F_CMP: begin
        if (!(spx.nonempty && spy.nonempty)) begin
          state_d = F_IDLE;
        end else if (lum > cfg_i.max_luminance) begin
          state_d = F_MUL;
        end else begin
          state_d = F_CSW;
        end
      end
      F_MUL: state_d = F_DIV;
      F_DIV: begin
        if (cnt_q == 5'd31) begin
          state_d = (ch_q == 2'd2) ? F_CSW : F_MUL;
        end
      end
      F_CSW: state_d = F_PUSH;
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != F_IDLE) || bstat_i.clearing;
    push_o     = (state_q == F_PUSH) && !full_i;
  end

  always_comb begin
    job_o.is_table  = item_q.kind;
    job_o.tab_index = item_q.table_index;
    job_o.tab_value = item_q.table_value;
    job_o.csw_red   = csw_q[0];
    job_o.csw_green = csw_q[1];
    job_o.csw_blue  = csw_q[2];
    job_o.ctr_x     = 17'(item_q.pos_x) - 17'sd128;
    job_o.ctr_y     = 17'(item_q.pos_y) - 17'sd128;
    job_o.x_lo      = spx_q.lo;
    job_o.x_hi      = spx_q.hi;
    job_o.y_lo      = spy_q.lo;
    job_o.y_hi      = spy_q.hi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          item_q   <= in_data_i;
          col_q[0] <= in_data_i.red;
          col_q[1] <= in_data_i.green;
          col_q[2] <= in_data_i.blue;
        end
      end
      F_LUM: begin
        lprod_q[0] <= 48'(item_q.red) * 48'(LUM_R);
        lprod_q[1] <= 48'(item_q.green) * 48'(LUM_G);
        lprod_q[2] <= 48'(item_q.blue) * 48'(LUM_B);
      end
      F_CMP: begin
        lum_q <= lum;
        spx_q <= spx;
        spy_q <= spy;
        ch_q  <= '0;
      end
      F_MUL: begin
        rem_q <= num[63:32];
        shf_q <= num[31:0];
        cnt_q <= '0;
      end
      F_DIV: begin
        rem_q <= rem_div;
        shf_q <= shf_div;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          col_q[ch_q] <= shf_div;
          ch_q        <= ch_q + 2'd1;
        end
      end
      F_CSW: begin
        csw_q[0] <= ACC_W'(col_q[0]) * ACC_W'(item_q.sample_weight);
        csw_q[1] <= ACC_W'(col_q[1]) * ACC_W'(item_q.sample_weight);
        csw_q[2] <= ACC_W'(col_q[2]) * ACC_W'(item_q.sample_weight);
      end
      default: ;
    endcase
  end

endmodule

// ===== src/fsta_back.sv =====
// back: clears the accumulators, writes the filter table and sweeps footprints
// depends on fsta_pkg and fsta_ram
module fsta_back import fsta_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  job_t         job_i,
  input  logic         empty_i,
  output logic         pop_o,
  output back_status_t bstat_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output out_item_t    out_data_o
);

  localparam int OffW = 2 * SLOT_W + 1;

  back_state_e              state_q, state_d;
  logic [ACC_AW-1:0]        clr_q;
  job_t                     job_q;
  logic [CRD_W-1:0]         x_q, y_q;
  logic [SLOT_W-1:0]        ty_q;
  logic                     oob_q;
  logic [ACC_AW-1:0]        addr_q;
  logic [55:0]              m_q [3];
  logic                     neg_q;
  logic signed [15:0]       w_q;
  logic                     out_valid_q;
  out_item_t                out_q;

  logic                     in_row;
  logic [CRD_W-1:0]         pix;
  logic signed [16:0]       ctr;
  logic [19:0]              scale;
  logic signed [DIST_W-1:0] pix_s, delta;
  logic [DIST_W-1:0]        mag;
  logic [DIST_W+19:0]       prod_s;
  logic [SLOT_W-1:0]        slot;
  logic [OffW-1:0]          off;
  logic                     tab_we, tab_re, acc_we, acc_re;
  logic [ACC_AW-1:0]        acc_waddr, acc_raddr;
  logic [ACC_ROW_W-1:0]     acc_wdata, acc_rdata;
  logic [15:0]              tab_rdata;
  logic signed [15:0]       w;
  logic [16:0]              wmag;
  logic                     fire, x_end, y_end;
  logic signed [ACC_W-1:0]  old_r, old_g, old_b, new_r, new_g, new_b;
  logic signed [WGT_W-1:0]  old_w, new_w;
  logic signed [WGT_W:0]    wsum;

  function automatic logic signed [ACC_W-1:0] add_sat(logic signed [ACC_W-1:0] acc,
                                                      logic [55:0] m, logic neg);
    logic signed [57:0] t, s;
    t = $signed({2'b00, m});
    if (neg) begin
      t = -t;
    end
    s = 58'(acc) + t;
    if (!s[57] && (|s[56:47])) begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end else if (s[57] && !(&s[56:47])) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end
    return s[ACC_W-1:0];
  endfunction

  // table slot, shared between the row step and each pixel step
  assign in_row = (state_q == B_ROW);
  assign pix    = in_row ? y_q : x_q;
  assign ctr    = in_row ? job_q.ctr_y : job_q.ctr_x;
  assign scale  = in_row ? cfg_i.table_scale_y : cfg_i.table_scale_x;
  assign pix_s  = DIST_W'({pix, 8'h00});
  assign delta  = pix_s - DIST_W'(ctr);
  assign mag    = (delta < 18'sd0) ? DIST_W'(-delta) : DIST_W'(delta);
  assign prod_s = (DIST_W+20)'(mag) * (DIST_W+20)'(scale);
  assign slot   = (prod_s[DIST_W+19:16] > (DIST_W+4)'(TABLE_EXTENT-1)) ?
                  SLOT_W'(TABLE_EXTENT-1) : prod_s[SLOT_W+15:16];
  assign off    = OffW'(ty_q) * OffW'(TABLE_EXTENT) + OffW'(slot);

  assign w      = oob_q ? 16'sd0 : $signed(tab_rdata);
  assign wmag   = (w < 16'sd0) ? 17'(-17'(w)) : 17'(w);

  assign {old_r, old_g, old_b, old_w} = acc_rdata;
  assign new_r  = add_sat(old_r, m_q[0], neg_q);
  assign new_g  = add_sat(old_g, m_q[1], neg_q);
  assign new_b  = add_sat(old_b, m_q[2], neg_q);
  assign wsum   = (WGT_W+1)'(old_w) + (WGT_W+1)'(w_q);
  assign new_w  = (wsum[WGT_W] != wsum[WGT_W-1]) ?
                  {wsum[WGT_W], {(WGT_W-1){!wsum[WGT_W]}}} : wsum[WGT_W-1:0];

  assign fire   = (state_q == B_ACC) && (!out_valid_q || !out_stall_i);
  assign x_end  = (x_q == job_q.x_hi - CRD_W'(1));
  assign y_end  = (y_q == job_q.y_hi - CRD_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR: begin
        if (clr_q == ACC_AW'(ACC_DEPTH-1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i && !job_i.is_table) begin
          state_d = B_ROW;
        end
      end
      B_ROW: state_d = B_IDX;
      B_IDX: state_d = B_MUL;
      B_MUL: state_d = B_ACC;
      B_ACC: begin
        if (fire) begin
          if (!x_end) begin
            state_d = B_IDX;
          end else if (!y_end) begin
            state_d = B_ROW;
          end else begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o            = (state_q == B_IDLE) && !empty_i;
    bstat_o.clearing = (state_q == B_CLEAR);
    tab_we           = pop_o && job_i.is_table;
    tab_re           = (state_q == B_IDX);
    acc_re           = (state_q == B_IDX);
    acc_raddr        = ACC_AW'(y_q) * ACC_AW'(TILE_MAX_WIDTH) + ACC_AW'(x_q);
    acc_we           = (state_q == B_CLEAR) || fire;
    acc_waddr        = (state_q == B_CLEAR) ? clr_q : addr_q;
    acc_wdata        = (state_q == B_CLEAR) ? '0 : {new_r, new_g, new_b, new_w};
  end

  fsta_ram #(.Width(16), .Depth(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (job_i.tab_index[TABLE_AW-1:0]),
    .wdata_i (job_i.tab_value),
    .re_i    (tab_re),
    .raddr_i (TABLE_AW'(off)),
    .rdata_o (tab_rdata)
  );

  fsta_ram #(.Width(ACC_ROW_W), .Depth(ACC_DEPTH)) u_acc (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_q <= clr_q + ACC_AW'(1);
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (pop_o && !job_i.is_table) begin
          job_q <= job_i;
          x_q   <= job_i.x_lo;
          y_q   <= job_i.y_lo;
        end
      end
      B_ROW: ty_q <= slot;
      B_IDX: begin
        oob_q  <= (off >= OffW'(TABLE_DEPTH));
        addr_q <= acc_raddr;
      end
      B_MUL: begin
        m_q[0] <= 56'((65'(job_q.csw_red) * 65'(wmag)) >> 8);
        m_q[1] <= 56'((65'(job_q.csw_green) * 65'(wmag)) >> 8);
        m_q[2] <= 56'((65'(job_q.csw_blue) * 65'(wmag)) >> 8);
        neg_q  <= (w < 16'sd0);
        w_q    <= w;
      end
      B_ACC: begin
        if (fire) begin
          out_q.pixel_x      <= x_q[5:0];
          out_q.pixel_y      <= y_q[5:0];
          out_q.sum_red      <= new_r;
          out_q.sum_green    <= new_g;
          out_q.sum_blue     <= new_b;
          out_q.weight_total <= new_w;
          out_q.last         <= x_end && y_end;
          if (x_end) begin
            x_q <= job_q.x_lo;
            y_q <= y_q + CRD_W'(1);
          end else begin
            x_q <= x_q + CRD_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/filtered_sample_tile_accumulator_top.sv =====
// Filtered sample tile accumulator, top level.
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction is either a
// filter-table word write or an image sample. Output channel (out_valid_o /
// out_stall_i / out_data_o): one transaction per updated pixel, row-major, with
// last set on the final pixel of a sample's footprint; an empty footprint and a
// table write give none. Configuration (cfg_valid_i / cfg_ready_o / cfg_index_i /
// cfg_data_i) is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. The front takes one transaction at a
// time and holds in_stall_o until it has queued the job or dropped an empty
// footprint; when the luminance cap bites it runs three 32-step restoring divides,
// one quotient bit per cycle. A 2-entry job queue sits between front and back.
// The back writes a table word as it pops it; for a sample it runs a row step per
// footprint row and index, multiply and accumulate steps per pixel, set by the
// read-modify-write of the single accumulator memory.
// After reset the back runs a clearing pass over the whole accumulator
// memory, during which in_stall_o is high. When out_stall_i holds the output
// register, the back waits in its write-back step and the queue then fills,
// after which the front raises in_stall_o.
// depends on fsta_pkg, fsta_front, fsta_queue, fsta_back
module filtered_sample_tile_accumulator_top import fsta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t         cfg_q;
  back_status_t bstat;
  job_t         push_job, head_job;
  logic         push, full, pop, empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tile_width    <= 7'd64;
      cfg_q.tile_height   <= 7'd64;
      cfg_q.radius_x      <= 10'd512;
      cfg_q.radius_y      <= 10'd512;
      cfg_q.table_scale_x <= 20'd2048;
      cfg_q.table_scale_y <= 20'd2048;
      cfg_q.max_luminance <= 32'hFFFF_FFFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TILE_WIDTH:    cfg_q.tile_width    <= cfg_data_i[6:0];
        CFG_TILE_HEIGHT:   cfg_q.tile_height   <= cfg_data_i[6:0];
        CFG_RADIUS_X:      cfg_q.radius_x      <= cfg_data_i[9:0];
        CFG_RADIUS_Y:      cfg_q.radius_y      <= cfg_data_i[9:0];
        CFG_TABLE_SCALE_X: cfg_q.table_scale_x <= cfg_data_i[19:0];
        CFG_TABLE_SCALE_Y: cfg_q.table_scale_y <= cfg_data_i[19:0];
        CFG_MAX_LUMINANCE: cfg_q.max_luminance <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fsta_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .bstat_i    (bstat),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  fsta_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (empty)
  );

  fsta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (head_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .bstat_o     (bstat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/fsta_checker.sv =====
// port-level checks for the filtered sample tile accumulator, bound to the top level
// depends on fsta_pkg
module fsta_checker import fsta_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // the front is busy in the cycle after every transaction it takes
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on two consecutive cycles");

  // held result stays put while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // clearing pass keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input open during accumulator clear");

endmodule

bind filtered_sample_tile_accumulator_top fsta_checker u_fsta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== test/fsta_checker.sv =====
// checker for the filtered sample tile accumulator: watches all three channels,
// predicts every updated pixel and compares it with what the block delivers
// depends on fsta_pkg
module fsta_tb_checker import fsta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MIN48 = -MAX48 - 1;
  localparam longint MAX32 = 64'sh0000_0000_7FFF_FFFF;
  localparam longint MIN32 = -MAX32 - 1;

  cfg_t                   cfg;
  logic signed [47:0]     acc_red   [ACC_DEPTH];
  logic signed [47:0]     acc_green [ACC_DEPTH];
  logic signed [47:0]     acc_blue  [ACC_DEPTH];
  logic signed [31:0]     acc_wgt   [ACC_DEPTH];
  logic signed [15:0]     filter_tab [TABLE_DEPTH];
  out_item_t              pixel_q [$];

  // covered pixel range [lo, hi) along one axis, clipped to the tile
  function automatic void footprint(input int pos, input int rad, input int ext,
                                    output int lo, output int hi);
    int d, r;
    d  = pos - 128;
    r  = (rad > RADIUS_CAP) ? RADIUS_CAP : rad;
    lo = -((r - d) >>> 8);
    hi = ((d + r) >>> 8) + 1;
    if (lo < 0) lo = 0;
    if (hi > ext) hi = ext;
  endfunction

  function automatic int filter_slot(int pix, int ctr, longint unsigned scale);
    int delta;
    longint unsigned mag, idx;
    delta = pix * 256 - ctr;
    mag   = (delta < 0) ? longint'(-delta) : longint'(delta);
    idx   = (mag * scale) >> 16;
    return (idx > TABLE_EXTENT - 1) ? TABLE_EXTENT - 1 : int'(idx);
  endfunction

  function automatic longint weighted(longint unsigned c, longint unsigned sw, int w);
    longint unsigned mag;
    longint m;
    mag = (w < 0) ? longint'(-w) : longint'(w);
    m   = longint'((c * sw * mag) >> 8);
    return (w < 0) ? -m : m;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void splat_sample(in_item_t it);
    longint unsigned r, g, b, sw, lum, cap;
    int x0, x1, y0, y1, ty, tx, off, w, a, wext, hext;
    out_item_t px;
    if (it.kind) begin
      filter_tab[it.table_index] = it.table_value;
      return;
    end
    r   = it.red;
    g   = it.green;
    b   = it.blue;
    sw  = it.sample_weight;
    cap = cfg.max_luminance;
    lum = (64'(LUM_R) * r + 64'(LUM_G) * g + 64'(LUM_B) * b) >> 16;
    if (lum > cap) begin
      r = r * cap / lum;
      g = g * cap / lum;
      b = b * cap / lum;
    end
    wext = (cfg.tile_width > TILE_MAX_WIDTH) ? TILE_MAX_WIDTH : cfg.tile_width;
    hext = (cfg.tile_height > TILE_MAX_HEIGHT) ? TILE_MAX_HEIGHT : cfg.tile_height;
    footprint(it.pos_x, cfg.radius_x, wext, x0, x1);
    footprint(it.pos_y, cfg.radius_y, hext, y0, y1);
    if (x1 <= x0 || y1 <= y0) return;
    for (int y = y0; y < y1; y++) begin
      ty = filter_slot(y, int'(it.pos_y) - 128, cfg.table_scale_y);
      for (int x = x0; x < x1; x++) begin
        tx  = filter_slot(x, int'(it.pos_x) - 128, cfg.table_scale_x);
        off = ty * TABLE_EXTENT + tx;
        w   = (off < TABLE_DEPTH) ? int'(filter_tab[off]) : 0;
        a   = y * TILE_MAX_WIDTH + x;
        acc_red[a]   = 48'(clamp(longint'(acc_red[a]) + weighted(r, sw, w), MIN48, MAX48));
        acc_green[a] = 48'(clamp(longint'(acc_green[a]) + weighted(g, sw, w), MIN48, MAX48));
        acc_blue[a]  = 48'(clamp(longint'(acc_blue[a]) + weighted(b, sw, w), MIN48, MAX48));
        acc_wgt[a]   = 32'(clamp(longint'(acc_wgt[a]) + w, MIN32, MAX32));
        px.pixel_x      = 6'(x);
        px.pixel_y      = 6'(y);
        px.sum_red      = acc_red[a];
        px.sum_green    = acc_green[a];
        px.sum_blue     = acc_blue[a];
        px.weight_total = acc_wgt[a];
        px.last         = (y == y1 - 1) && (x == x1 - 1);
        pixel_q.push_back(px);
      end
    end
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      cfg = '{tile_width: 7'd64, tile_height: 7'd64, radius_x: 10'd512,
              radius_y: 10'd512, table_scale_x: 20'd2048, table_scale_y: 20'd2048,
              max_luminance: 32'hFFFF_FFFF};
      for (int i = 0; i < ACC_DEPTH; i++) begin
        acc_red[i]   = '0;
        acc_green[i] = '0;
        acc_blue[i]  = '0;
        acc_wgt[i]   = '0;
      end
      pixel_q.delete();
      fail_count_o = 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_TILE_WIDTH:    cfg.tile_width    = cfg_data_i[6:0];
          CFG_TILE_HEIGHT:   cfg.tile_height   = cfg_data_i[6:0];
          CFG_RADIUS_X:      cfg.radius_x      = cfg_data_i[9:0];
          CFG_RADIUS_Y:      cfg.radius_y      = cfg_data_i[9:0];
          CFG_TABLE_SCALE_X: cfg.table_scale_x = cfg_data_i[19:0];
          CFG_TABLE_SCALE_Y: cfg.table_scale_y = cfg_data_i[19:0];
          CFG_MAX_LUMINANCE: cfg.max_luminance = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) splat_sample(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: pixel transaction with none expected, actual %h", $time, out_data_i);
          fail_count_o++;
        end else begin
          e = pixel_q.pop_front();
          check_field("pixel_x", e.pixel_x, out_data_i.pixel_x);
          check_field("pixel_y", e.pixel_y, out_data_i.pixel_y);
          check_field("sum_red", e.sum_red, out_data_i.sum_red);
          check_field("sum_green", e.sum_green, out_data_i.sum_green);
          check_field("sum_blue", e.sum_blue, out_data_i.sum_blue);
          check_field("weight_total", e.weight_total, out_data_i.weight_total);
          check_field("last", e.last, out_data_i.last);
        end
      end
      pending_o <= pixel_q.size();
    end
  end

endmodule

// ===== test/filtered_sample_tile_accumulator_top_tb.sv =====
// testbench top for the filtered sample tile accumulator: drives samples, table
// words and register phases with random gaps and stalls, and gives the verdict
// depends on fsta_pkg, fsta_tb_checker and the block's top level
module filtered_sample_tile_accumulator_top_tb;
  import fsta_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 30000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          fail_count, pending;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;

  filtered_sample_tile_accumulator_top dut (.*);

  fsta_tb_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver side: a fresh stall length for every pixel transaction
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (out_valid_o) stall_left = quiet ? 0 : $urandom_range(0, 4);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // leaves valid high; the caller lowers it after the last register
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_tile(int w, int h, int rx, int ry, int sx, int sy, logic [31:0] cap);
    write_reg(CFG_TILE_WIDTH, w);
    write_reg(CFG_TILE_HEIGHT, h);
    write_reg(CFG_RADIUS_X, rx);
    write_reg(CFG_RADIUS_Y, ry);
    write_reg(CFG_TABLE_SCALE_X, sx);
    write_reg(CFG_TABLE_SCALE_Y, sy);
    write_reg(CFG_MAX_LUMINANCE, cap);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_colour();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return '0;
      2, 3:    return $urandom_range(0, 32'h000F_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.kind          = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 7) == 0) begin
      it.pos_x = $urandom;
      it.pos_y = $urandom;
    end else begin
      it.pos_x = 16'($urandom_range(0, 17408)) - 16'sd512;
      it.pos_y = 16'($urandom_range(0, 17408)) - 16'sd512;
    end
    it.red           = rand_colour();
    it.green         = rand_colour();
    it.blue          = rand_colour();
    it.sample_weight = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    it.table_index   = $urandom;
    it.table_value   = $urandom;
    return it;
  endfunction

  function automatic in_item_t sample_at(int x, int y, logic [31:0] c, logic [15:0] sw);
    in_item_t it;
    it = '0;
    it.pos_x = x;
    it.pos_y = y;
    it.red = c;
    it.green = c;
    it.blue = ~c;
    it.sample_weight = sw;
    return it;
  endfunction

  initial begin
    in_item_t it;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every filter entry is written before the first lookup
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      it = '0;
      it.kind = 1'b1;
      it.table_index = i;
      case (i % 17)
        0:       it.table_value = 16'sh7FFF;
        1:       it.table_value = 16'sh8000;
        2:       it.table_value = '0;
        default: it.table_value = $urandom;
      endcase
      it.pos_x = $urandom;
      it.red = $urandom;
      send_item(it);
    end

    // corners, edges, extreme positions and saturating colours
    send_item(sample_at(0, 0, 32'h0001_0000, 16'h0100));
    send_item(sample_at(128, 128, '1, 16'hFFFF));
    send_item(sample_at(128, 128, '1, 16'hFFFF));
    send_item(sample_at(16256, 16256, 32'h8000_0000, 16'hFFFF));
    send_item(sample_at(-32768, -32768, '1, 16'hFFFF));
    send_item(sample_at(32767, 32767, '1, 16'hFFFF));
    send_item(sample_at(-32768, 200, 32'h1234_5678, 16'h0080));
    send_item(sample_at(8000, 32767, 32'h5555_AAAA, 16'h0001));
    send_item(sample_at(1000, 1000, '0, 16'h0000));
    send_item(sample_at(16384, 16384, 32'hAAAA_5555, 16'h8000));
    send_item(sample_at(-600, 300, '1, 16'h7FFF));
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      quiet = (phase % 3 == 2);
      case (phase)
        0: set_tile(64, 64, 896, 896, 1170, 1170, '1);
        1: set_tile(1, 1, 1, 1, 0, 0, 32'h0);
        2: set_tile(127, 0, 1023, 1023, 20'hFFFFF, 20'hFFFFF, 32'h0001_0000);
        3: set_tile(8, 8, 384, 640, $urandom_range(0, 20'hFFFFF),
                    $urandom_range(0, 8000), $urandom);
        4: set_tile(64, 1, 896, 1, 4096, 0, 32'hFFFF_FFFF);
        default: set_tile($urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(1, 1023), $urandom_range(1, 1023),
                          $urandom_range(0, 20'hFFFFF), $urandom_range(0, 12000),
                          ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h00FF_FFFF)));
      endcase
      if (phase == 3) begin
        write_reg(CFG_UNUSED, '1);
        cfg_valid_i <= 1'b0;
        @(negedge clk_i);
      end
      for (int n = 0; n < 10; n++) send_item(rand_item());
      drain();
    end

    // wind down at a smaller tile with the cap removed
    set_tile(16, 16, 512, 512, 2048, 2048, '1);
    for (int n = 0; n < 10; n++) send_item(rand_item());
    drain();

    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
